>>> design/msp_style_frame_parser_top_defines.svh
`ifndef MSP_STYLE_FRAME_PARSER_TOP_DEFINES_SVH
`define MSP_STYLE_FRAME_PARSER_TOP_DEFINES_SVH

// assertion on an explicit clock and active-low reset
`define MSPFP_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the usual clk_i / rst_ni pair
`define MSPFP_ASSERT(lbl, prop, msg) \
  `MSPFP_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> design/mspfp_pkg.sv
package mspfp_pkg;

  localparam logic [7:0] HdrFirst      = 8'h24;
  localparam logic [7:0] HdrSecond     = 8'h4D;
  localparam logic [7:0] MaxPayloadRst = 8'd64;
  localparam int unsigned TdataW       = 32;

  typedef enum logic [2:0] {
    PH_DOLLAR = 3'd0,
    PH_EM     = 3'd1,
    PH_DIR    = 3'd2,
    PH_SIZE   = 3'd3,
    PH_DATA   = 3'd4,
    PH_CHECK  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_TOO_LONG   = 2'd2,
    ST_BAD_CHECK  = 2'd3
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [7:0] frame_dir;
    logic [7:0] frame_size;
    status_e    status;
  } res_t;

endpackage

>>> design/mspfp_skid.sv
`include "msp_style_frame_parser_top_defines.svh"

module mspfp_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mspfp_pkg::res_t  in_res_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mspfp_pkg::res_t  out_res_o
);

  logic            out_vld_q, out_vld_d;
  logic            skid_vld_q, skid_vld_d;
  mspfp_pkg::res_t out_q, out_d;
  mspfp_pkg::res_t skid_q, skid_d;

  assign in_ready_o  = !skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (out_ready_i || !out_vld_q) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_d     = in_res_i;
        out_vld_d = in_valid_i;
      end
    end else if (in_valid_i && !skid_vld_q) begin
      // output stalled, park the transaction in the skid stage
      skid_d     = in_res_i;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  `MSPFP_ASSERT(a_skid_implies_out, skid_vld_q |-> out_vld_q, "skid full with empty output")
  `MSPFP_ASSERT(a_stall_parks, (in_valid_i && in_ready_o && out_vld_q && !out_ready_i) |=> skid_vld_q, "stalled transaction lost")

endmodule

>>> design/msp_style_frame_parser_top.sv
// Byte-stream deframer for '$' 'M' dir size payload check frames. One byte is taken on the
// slave stream per cycle while s_axis_tready_o is high; each payload byte leaves as a payload
// item (tuser 0) and every frame or header error ends with one status item (tuser 1) carrying
// direction, size and status (0 ok, 1 bad header, 2 too long, 3 bad check byte). The parser
// step is combinational, and its result is registered in the output register on the master
// side, or in a one-entry skid stage while the master stream stalls; s_axis_tready_o drops
// only while the skid stage holds a result. The payload length limit (reset 64) is written
// over the cfg channel by the user, only while the stream is idle; the block does not enforce this.
`include "msp_style_frame_parser_top_defines.svh"

module msp_style_frame_parser_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,  // byte_in
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // data_byte, frame_dir, frame_size, status, zero fill
  output logic [mspfp_pkg::TdataW-1:0]   m_axis_tdata_o,
  output logic                           m_axis_tuser_o,  // kind
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [7:0]                     cfg_data_i       // payload length limit
);

  mspfp_pkg::phase_e phase_q, phase_d;
  logic [7:0]        bytes_left_q, bytes_left_d;
  logic [7:0]        check_acc_q, check_acc_d;
  logic [7:0]        dir_q, dir_d;
  logic [7:0]        size_q, size_d;
  logic [7:0]        len_limit_q;
  logic              in_acc;
  logic              in_ready;
  logic              res_valid;
  mspfp_pkg::res_t   res;
  mspfp_pkg::res_t   out_res;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = in_ready;
  assign in_acc          = s_axis_tvalid_i && in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_limit_q <= mspfp_pkg::MaxPayloadRst;
    end else if (cfg_valid_i) begin
      len_limit_q <= cfg_data_i;
    end
  end

  // next state
  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    check_acc_d  = check_acc_q;
    dir_d        = dir_q;
    size_d       = size_q;
    if (in_acc) begin
      unique case (phase_q)
        mspfp_pkg::PH_EM: begin
          phase_d = (s_axis_tdata_i == mspfp_pkg::HdrSecond) ? mspfp_pkg::PH_DIR
                                                              : mspfp_pkg::PH_DOLLAR;
        end
        mspfp_pkg::PH_DIR: begin
          dir_d   = s_axis_tdata_i;
          phase_d = mspfp_pkg::PH_SIZE;
        end
        mspfp_pkg::PH_SIZE: begin
          size_d = s_axis_tdata_i;
          if (s_axis_tdata_i > len_limit_q) begin
            phase_d = mspfp_pkg::PH_DOLLAR;
          end else begin
            check_acc_d  = s_axis_tdata_i;
            bytes_left_d = s_axis_tdata_i;
            phase_d = (s_axis_tdata_i == 8'd0) ? mspfp_pkg::PH_CHECK : mspfp_pkg::PH_DATA;
          end
        end
        mspfp_pkg::PH_DATA: begin
          check_acc_d  = check_acc_q ^ s_axis_tdata_i;
          bytes_left_d = bytes_left_q - 8'd1;
          if (bytes_left_q == 8'd1) begin
            phase_d = mspfp_pkg::PH_CHECK;
          end
        end
        mspfp_pkg::PH_CHECK: begin
          phase_d = mspfp_pkg::PH_DOLLAR;
        end
        default: begin
          phase_d = (s_axis_tdata_i == mspfp_pkg::HdrFirst) ? mspfp_pkg::PH_EM
                                                             : mspfp_pkg::PH_DOLLAR;
        end
      endcase
    end
  end

  // result for the byte being taken
  always_comb begin
    res_valid      = 1'b0;
    res.kind       = mspfp_pkg::KIND_STATUS;
    res.data_byte  = 8'd0;
    res.frame_dir  = 8'd0;
    res.frame_size = 8'd0;
    res.status     = mspfp_pkg::ST_OK;
    unique case (phase_q)
      mspfp_pkg::PH_EM: begin
        res_valid  = (s_axis_tdata_i != mspfp_pkg::HdrSecond);
        res.status = mspfp_pkg::ST_BAD_HEADER;
      end
      mspfp_pkg::PH_DIR: begin
        res_valid = 1'b0;
      end
      mspfp_pkg::PH_SIZE: begin
        res_valid      = (s_axis_tdata_i > len_limit_q);
        res.frame_dir  = dir_q;
        res.frame_size = s_axis_tdata_i;
        res.status     = mspfp_pkg::ST_TOO_LONG;
      end
      mspfp_pkg::PH_DATA: begin
        res_valid     = 1'b1;
        res.kind      = mspfp_pkg::KIND_PAYLOAD;
        res.data_byte = s_axis_tdata_i;
      end
      mspfp_pkg::PH_CHECK: begin
        res_valid      = 1'b1;
        res.frame_dir  = dir_q;
        res.frame_size = size_q;
        res.status     = (s_axis_tdata_i == check_acc_q) ? mspfp_pkg::ST_OK
                                                         : mspfp_pkg::ST_BAD_CHECK;
      end
      default: begin
        res_valid  = (s_axis_tdata_i != mspfp_pkg::HdrFirst);
        res.status = mspfp_pkg::ST_BAD_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= mspfp_pkg::PH_DOLLAR;
      bytes_left_q <= 8'd0;
      check_acc_q  <= 8'd0;
      dir_q        <= 8'd0;
      size_q       <= 8'd0;
    end else begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      check_acc_q  <= check_acc_d;
      dir_q        <= dir_d;
      size_q       <= size_d;
    end
  end

  mspfp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_acc && res_valid),
    .in_ready_o  (in_ready),
    .in_res_i    (res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (out_res)
  );

  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tdata_o = {6'd0, out_res.status, out_res.frame_size, out_res.frame_dir,
                           out_res.data_byte};

  `MSPFP_ASSERT(a_data_count_live, (phase_q == mspfp_pkg::PH_DATA) |-> (bytes_left_q != 8'd0), "payload phase with no bytes left")
  `MSPFP_ASSERT(a_check_count_done, (phase_q == mspfp_pkg::PH_CHECK) |-> (bytes_left_q == 8'd0), "check phase with bytes left")
  `MSPFP_ASSERT(a_payload_clean, (res_valid && res.kind == mspfp_pkg::KIND_PAYLOAD) |-> (res.status == mspfp_pkg::ST_OK && res.frame_dir == 8'd0 && res.frame_size == 8'd0), "payload item with frame fields set")

endmodule
